>>> design/hrsp_pkg.sv
`default_nettype none
package hrsp_pkg;

	// character codes
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// field tags
	localparam logic [3:0] TAG_METHOD   = 4'd0;
	localparam logic [3:0] TAG_URL      = 4'd1;
	localparam logic [3:0] TAG_VERSION  = 4'd2;
	localparam logic [3:0] TAG_NAME     = 4'd3;
	localparam logic [3:0] TAG_HOST     = 4'd4;
	localparam logic [3:0] TAG_CONN     = 4'd5;
	localparam logic [3:0] TAG_OTHER    = 4'd6;
	localparam logic [3:0] TAG_BODY     = 4'd7;
	localparam logic [3:0] TAG_LINE_END = 4'd8;
	localparam logic [3:0] TAG_HDR_END  = 4'd9;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_REQ  = 2'd1;
	localparam logic [1:0] ERR_HDR  = 2'd2;

	// header value kinds
	localparam logic [1:0] VK_OTHER = 2'd0;
	localparam logic [1:0] VK_HOST  = 2'd1;
	localparam logic [1:0] VK_CONN  = 2'd2;

	// result queue sizing
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		PH_REQ  = 3'b001,
		PH_HDR  = 3'b010,
		PH_BODY = 3'b100
	} hrsp_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
	} hrsp_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] field_tag;
		logic [1:0] error_code;
		logic       last;
	} hrsp_out_t;

	typedef struct packed {
		hrsp_phase_t phase;
		logic [7:0]  held_byte;
		logic        held_valid;
		logic [1:0]  dcount;
		logic [3:0]  npos;
		logic [1:0]  kmatch;
		logic [1:0]  vkind;
		logic        line_empty;
		logic        drop_rest;
	} hrsp_state_t;

	typedef struct packed {
		hrsp_state_t st;
		hrsp_out_t   r0;
		hrsp_out_t   r1;
		logic [1:0]  n;
	} hrsp_work_t;

	// results handed from the parser to the result queue
	typedef struct packed {
		logic [1:0] n;
		hrsp_out_t  r0;
		hrsp_out_t  r1;
	} hrsp_push_t;

	function automatic logic [7:0] kw_host_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = 8'h68;
			2'd1: c = 8'h6f;
			2'd2: c = 8'h73;
			default: c = 8'h74;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_conn_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = 8'h63;
			4'd1: c = 8'h6f;
			4'd2: c = 8'h6e;
			4'd3: c = 8'h6e;
			4'd4: c = 8'h65;
			4'd5: c = 8'h63;
			4'd6: c = 8'h74;
			4'd7: c = 8'h69;
			4'd8: c = 8'h6f;
			4'd9: c = 8'h6e;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> design/hrsp_core.sv
`default_nettype none
module hrsp_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	input  wire hrsp_pkg::hrsp_in_t  rx_item,
	input  wire logic                room,
	output hrsp_pkg::hrsp_push_t     push
);

	logic                  valid_s1;
	hrsp_pkg::hrsp_in_t    item_s1;
	hrsp_pkg::hrsp_state_t st_q;
	hrsp_pkg::hrsp_work_t  w;
	logic                  consume;

	function automatic hrsp_pkg::hrsp_state_t f_line_reset(input hrsp_pkg::hrsp_state_t s);
		hrsp_pkg::hrsp_state_t o;
		o = s;
		o.held_valid = 1'b0;
		o.held_byte  = 8'd0;
		o.dcount     = 2'd0;
		o.npos       = 4'd0;
		o.kmatch     = 2'b11;
		o.vkind      = hrsp_pkg::VK_OTHER;
		o.line_empty = 1'b1;
		return o;
	endfunction

	function automatic hrsp_pkg::hrsp_work_t f_emit(input hrsp_pkg::hrsp_work_t wi,
		input logic [7:0] b, input logic [3:0] tag, input logic [1:0] err);
		hrsp_pkg::hrsp_work_t o;
		hrsp_pkg::hrsp_out_t  r;
		o = wi;
		r.out_byte   = b;
		r.field_tag  = tag;
		r.error_code = err;
		r.last       = 1'b0;
		if (wi.n == 2'd0) begin
			o.r0 = r;
			o.n  = 2'd1;
		end else if (wi.n == 2'd1) begin
			o.r1 = r;
			o.n  = 2'd2;
		end
		return o;
	endfunction

	function automatic hrsp_pkg::hrsp_work_t f_raise(input hrsp_pkg::hrsp_work_t wi,
		input logic [1:0] err);
		hrsp_pkg::hrsp_work_t o;
		o = f_emit(wi, 8'd0, hrsp_pkg::TAG_LINE_END, err);
		o.st = f_line_reset(o.st);
		o.st.drop_rest = 1'b1;
		return o;
	endfunction

	function automatic hrsp_pkg::hrsp_work_t f_content(input hrsp_pkg::hrsp_work_t wi,
		input logic [7:0] b);
		hrsp_pkg::hrsp_work_t o;
		logic [7:0]           lb;
		logic [3:0]           tag;
		o = wi;
		o.st.line_empty = 1'b0;
		lb = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
		if (wi.st.phase != hrsp_pkg::PH_HDR) begin
			// request line piece follows the space count
			tag = (wi.st.dcount == 2'd3) ? hrsp_pkg::TAG_VERSION : {2'b00, wi.st.dcount};
			o = f_emit(o, b, tag, hrsp_pkg::ERR_NONE);
		end else if (wi.st.dcount != 2'd0) begin
			case (wi.st.vkind)
				hrsp_pkg::VK_HOST: tag = hrsp_pkg::TAG_HOST;
				hrsp_pkg::VK_CONN: tag = hrsp_pkg::TAG_CONN;
				default:           tag = hrsp_pkg::TAG_OTHER;
			endcase
			o = f_emit(o, lb, tag, hrsp_pkg::ERR_NONE);
		end else begin
			// header name: track the two keywords
			if (wi.st.npos >= 4'd4 || hrsp_pkg::kw_host_char(wi.st.npos[1:0]) != lb)
				o.st.kmatch[0] = 1'b0;
			if (wi.st.npos >= 4'd10 || hrsp_pkg::kw_conn_char(wi.st.npos) != lb)
				o.st.kmatch[1] = 1'b0;
			if (wi.st.npos != 4'd15)
				o.st.npos = wi.st.npos + 4'd1;
			o = f_emit(o, lb, hrsp_pkg::TAG_NAME, hrsp_pkg::ERR_NONE);
		end
		return o;
	endfunction

	function automatic hrsp_pkg::hrsp_work_t f_end_line(input hrsp_pkg::hrsp_work_t wi);
		hrsp_pkg::hrsp_work_t o;
		o = wi;
		if (wi.st.phase == hrsp_pkg::PH_HDR) begin
			if (wi.st.line_empty) begin
				o = f_emit(o, 8'd0, hrsp_pkg::TAG_HDR_END, hrsp_pkg::ERR_NONE);
				o.st.phase = hrsp_pkg::PH_BODY;
			end else if (wi.st.dcount != 2'd1) begin
				return f_raise(o, hrsp_pkg::ERR_HDR);
			end else begin
				o = f_emit(o, 8'd0, hrsp_pkg::TAG_LINE_END, hrsp_pkg::ERR_NONE);
			end
		end else begin
			if (wi.st.dcount != 2'd2)
				return f_raise(o, hrsp_pkg::ERR_REQ);
			o = f_emit(o, 8'd0, hrsp_pkg::TAG_LINE_END, hrsp_pkg::ERR_NONE);
			o.st.phase = hrsp_pkg::PH_HDR;
		end
		o.st = f_line_reset(o.st);
		return o;
	endfunction

	function automatic hrsp_pkg::hrsp_work_t f_colon_space(input hrsp_pkg::hrsp_work_t wi);
		hrsp_pkg::hrsp_work_t o;
		o = wi;
		o.st.line_empty = 1'b0;
		if (wi.st.dcount != 2'd0)
			return f_raise(o, hrsp_pkg::ERR_HDR);
		o.st.dcount = 2'd1;
		if (wi.st.kmatch[0] && wi.st.npos == 4'd4)
			o.st.vkind = hrsp_pkg::VK_HOST;
		else if (wi.st.kmatch[1] && wi.st.npos == 4'd10)
			o.st.vkind = hrsp_pkg::VK_CONN;
		else
			o.st.vkind = hrsp_pkg::VK_OTHER;
		return o;
	endfunction

	function automatic hrsp_pkg::hrsp_work_t f_fresh(input hrsp_pkg::hrsp_work_t wi,
		input logic [7:0] b);
		hrsp_pkg::hrsp_work_t o;
		o = wi;
		if (b == hrsp_pkg::CH_CR ||
		    (wi.st.phase == hrsp_pkg::PH_HDR && b == hrsp_pkg::CH_COLON)) begin
			o.st.held_byte  = b;
			o.st.held_valid = 1'b1;
		end else if (wi.st.phase != hrsp_pkg::PH_HDR && b == hrsp_pkg::CH_SPACE) begin
			o.st.line_empty = 1'b0;
			if (wi.st.dcount >= 2'd2)
				o = f_raise(o, hrsp_pkg::ERR_REQ);
			else
				o.st.dcount = wi.st.dcount + 2'd1;
		end else begin
			o = f_content(o, b);
		end
		return o;
	endfunction

	// input register moves on whenever the queue can take two results
	assign consume  = valid_s1 && room;
	assign rx_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			item_s1 <= rx_item;
		end
	end

	// per-byte parse step
	always_comb begin
		logic [7:0] h;
		logic       done;
		w      = '0;
		w.st   = st_q;
		w.n    = 2'd0;
		h      = st_q.held_byte;
		done   = 1'b0;
		if (!st_q.drop_rest) begin
			if (st_q.phase == hrsp_pkg::PH_BODY) begin
				w = f_emit(w, item_s1.data_byte, hrsp_pkg::TAG_BODY, hrsp_pkg::ERR_NONE);
			end else begin
				if (st_q.held_valid) begin
					w.st.held_valid = 1'b0;
					w.st.held_byte  = 8'd0;
					if (h == hrsp_pkg::CH_CR && item_s1.data_byte == hrsp_pkg::CH_LF) begin
						w    = f_end_line(w);
						done = 1'b1;
					end else if (h == hrsp_pkg::CH_COLON &&
					             item_s1.data_byte == hrsp_pkg::CH_SPACE) begin
						w    = f_colon_space(w);
						done = 1'b1;
					end else begin
						w = f_content(w, h);
					end
				end
				if (!done)
					w = f_fresh(w, item_s1.data_byte);
			end
		end
		// chunk end clears drop mode and closes the body
		if (item_s1.chunk_last) begin
			if (w.st.drop_rest) begin
				w.st = f_line_reset(w.st);
				w.st.drop_rest = 1'b0;
			end
			if (w.st.phase == hrsp_pkg::PH_BODY) begin
				w.st = f_line_reset(w.st);
				w.st.phase = hrsp_pkg::PH_REQ;
			end
		end
		// mark the final result of this byte
		if (w.n == 2'd1)
			w.r0.last = 1'b1;
		else if (w.n == 2'd2)
			w.r1.last = 1'b1;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= hrsp_pkg::PH_REQ;
			st_q.held_byte  <= 8'd0;
			st_q.held_valid <= 1'b0;
			st_q.dcount     <= 2'd0;
			st_q.npos       <= 4'd0;
			st_q.kmatch     <= 2'b11;
			st_q.vkind      <= hrsp_pkg::VK_OTHER;
			st_q.line_empty <= 1'b1;
			st_q.drop_rest  <= 1'b0;
		end else if (consume) begin
			st_q <= w.st;
		end
	end

	assign push.n  = consume ? w.n : 2'd0;
	assign push.r0 = w.r0;
	assign push.r1 = w.r1;

endmodule
`default_nettype wire

>>> design/hrsp_outq.sv
`default_nettype none
module hrsp_outq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hrsp_pkg::hrsp_push_t push,
	output logic                      room,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output hrsp_pkg::hrsp_out_t       res_item
);

	hrsp_pkg::hrsp_out_t               mem_q [hrsp_pkg::QDEPTH];
	logic [hrsp_pkg::QPTR_W-1:0]       wp_q;
	logic [hrsp_pkg::QPTR_W-1:0]       rp_q;
	logic [hrsp_pkg::QCNT_W-1:0]       cnt_q;
	logic                              pop;

	assign room      = cnt_q <= hrsp_pkg::QCNT_W'(hrsp_pkg::QDEPTH - 2);
	assign res_valid = cnt_q != '0;
	assign pop       = res_valid && res_ready;
	assign res_item  = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + hrsp_pkg::QPTR_W'(push.n);
			rp_q  <= rp_q + hrsp_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + hrsp_pkg::QCNT_W'(push.n) - hrsp_pkg::QCNT_W'(pop);
		end
	end

	// result storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + hrsp_pkg::QPTR_W'(1)] <= push.r1;
		end
	end

endmodule
`default_nettype wire

>>> design/http_request_stream_parser_top.sv
// Path: an accepted request is held in the input register, parsed and pushed into the
// result queue, which offers its results to the consumer.
// Throughput: one request per cycle while each yields one result and the queue has room for
// two; a request that yields two results holds the single result port for both, buffered by a 4-entry queue.
// Reset: arst_n clears the parser state to the request line phase and empties the
// input register and the result queue asynchronously.
`default_nettype none
module http_request_stream_parser_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	input  wire hrsp_pkg::hrsp_in_t  rx_item,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output hrsp_pkg::hrsp_out_t      res_item
);

	hrsp_pkg::hrsp_push_t push;
	logic                 room;

	// parse step behind the input register
	hrsp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_item  (rx_item),
		.room     (room),
		.push     (push)
	);

	// result queue toward the consumer
	hrsp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule
`default_nettype wire

>>> design/hrsp_checker.sv
`default_nettype none
module hrsp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                rx_valid,
	input wire logic                rx_ready,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire hrsp_pkg::hrsp_out_t res_item
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// errors only on a final line end event
	a_err_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.error_code != hrsp_pkg::ERR_NONE |->
		res_item.field_tag == hrsp_pkg::TAG_LINE_END && res_item.out_byte == 8'd0 &&
		res_item.last)
		else $error("error flagged on a non line end result");

	// both results of one request are queued together
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_item.last |=> res_valid)
		else $error("second result of a request missing");

	// results from an idle queue follow an accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result without a prior request");

endmodule

bind http_request_stream_parser_top hrsp_checker u_hrsp_checker (.*);
`default_nettype wire
